// ===== rtl/core/bounded_stack_with_palindrome_check_macros.svh =====
// Assertion macros for the stack block.
`ifndef BOUNDED_STACK_WITH_PALINDROME_CHECK_MACROS_SVH
`define BOUNDED_STACK_WITH_PALINDROME_CHECK_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BSPC_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BSPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BSPC_ASSERT(lbl, ante, cons, msg)

`define BSPC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/bspc_pkg.sv =====
`default_nettype none

package bspc_pkg;

    localparam int DEPTH_DFLT = 8;
    localparam int WORD_W     = 32;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_PUSH = 2'd0;
    localparam t_op OP_POP  = 2'd1;
    localparam t_op OP_PAL  = 2'd2;
    localparam t_op OP_LIST = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_OVERFLOW  = 2'd1;
    localparam t_status ST_UNDERFLOW = 2'd2;
    localparam t_status ST_EMPTY     = 2'd3;

    localparam logic [1:0] RD_TOP  = 2'd0;
    localparam logic [1:0] RD_PAIR = 2'd1;
    localparam logic [1:0] RD_DOWN = 2'd2;

    localparam logic [2:0] IDX_HOLD = 3'd0;
    localparam logic [2:0] IDX_CLR  = 3'd1;
    localparam logic [2:0] IDX_TOP  = 3'd2;
    localparam logic [2:0] IDX_INC  = 3'd3;
    localparam logic [2:0] IDX_DEC  = 3'd4;

    typedef struct packed {
        logic       load_item;
        logic       push_wr;
        logic       occ_inc;
        logic       occ_dec;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic [2:0] idx_op;
        logic       same_set;
        logic       same_upd;
        logic       out_load;
        t_status    out_status;
        logic       out_use_rd;
        logic       out_pal;
        logic       out_pal_same;
        logic       out_last;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic empty;
        logic idx_done;
        logic idx_zero;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/core/bspc_ifs.sv =====
`default_nettype none

interface bspc_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          operation;
    logic signed [bspc_pkg::WORD_W-1:0]  push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface bspc_out_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [bspc_pkg::WORD_W-1:0]  data_word;
    logic                                is_palindrome;
    logic                                last;

    modport source (output valid, output status, output data_word, output is_palindrome,
                    output last, input ready);
    modport sink   (input valid, input status, input data_word, input is_palindrome,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bspc_ctrl.sv =====
`default_nettype none

module bspc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire bspc_pkg::t_stat i_stat,
    output bspc_pkg::t_cmd       o_cmd,
    output logic                 o_in_ready
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DISP    = 3'd1;
    localparam logic [2:0] S_POP     = 3'd2;
    localparam logic [2:0] S_PAL_RD  = 3'd3;
    localparam logic [2:0] S_PAL_CMP = 3'd4;
    localparam logic [2:0] S_PAL_OUT = 3'd5;
    localparam logic [2:0] S_LIST    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.op)
                    bspc_pkg::OP_PUSH: begin
                        if (i_stat.out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_status = bspc_pkg::ST_OVERFLOW;
                            end else begin
                                o_cmd.out_status = bspc_pkg::ST_OK;
                                o_cmd.push_wr    = 1'b1;
                                o_cmd.occ_inc    = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    bspc_pkg::OP_POP: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = bspc_pkg::ST_UNDERFLOW;
                                o_cmd.out_last   = 1'b1;
                                n_state          = S_IDLE;
                            end
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_sel  = bspc_pkg::RD_TOP;
                            o_cmd.occ_dec = 1'b1;
                            n_state       = S_POP;
                        end
                    end
                    bspc_pkg::OP_PAL: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = bspc_pkg::ST_EMPTY;
                                o_cmd.out_pal    = 1'b1;
                                o_cmd.out_last   = 1'b1;
                                n_state          = S_IDLE;
                            end
                        end else begin
                            o_cmd.idx_op   = bspc_pkg::IDX_CLR;
                            o_cmd.same_set = 1'b1;
                            n_state        = S_PAL_RD;
                        end
                    end
                    bspc_pkg::OP_LIST: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = bspc_pkg::ST_EMPTY;
                                o_cmd.out_last   = 1'b1;
                                n_state          = S_IDLE;
                            end
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = bspc_pkg::RD_TOP;
                            o_cmd.idx_op = bspc_pkg::IDX_TOP;
                            n_state      = S_LIST;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_POP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = bspc_pkg::ST_OK;
                    o_cmd.out_use_rd = 1'b1;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_PAL_RD: begin
                if (i_stat.idx_done) begin
                    n_state = S_PAL_OUT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = bspc_pkg::RD_PAIR;
                    o_cmd.idx_op = bspc_pkg::IDX_INC;
                    n_state      = S_PAL_CMP;
                end
            end
            S_PAL_CMP: begin
                o_cmd.same_upd = 1'b1;
                n_state        = S_PAL_RD;
            end
            S_PAL_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_status   = bspc_pkg::ST_OK;
                    o_cmd.out_pal_same = 1'b1;
                    o_cmd.out_last     = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = bspc_pkg::ST_OK;
                    o_cmd.out_use_rd = 1'b1;
                    o_cmd.out_last   = i_stat.idx_zero;
                    if (i_stat.idx_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        // fetch the next word down while this one goes out
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = bspc_pkg::RD_DOWN;
                        o_cmd.idx_op = bspc_pkg::IDX_DEC;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/bspc_dp.sv =====
`default_nettype none

module bspc_dp #(
    parameter int DEPTH = bspc_pkg::DEPTH_DFLT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire bspc_pkg::t_cmd                     i_cmd,
    input  wire logic [1:0]                         i_operation,
    input  wire logic signed [bspc_pkg::WORD_W-1:0] i_push_value,
    input  wire logic                               i_out_ready,
    output bspc_pkg::t_stat                         o_stat,
    output logic                                    o_out_valid,
    output logic [1:0]                              o_status,
    output logic signed [bspc_pkg::WORD_W-1:0]      o_data_word,
    output logic                                    o_is_palindrome,
    output logic                                    o_last
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [bspc_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [CW-1:0]               r_occ;
    logic [CW-1:0]               r_idx;
    logic                        r_same;
    logic [1:0]                  r_op;
    logic [bspc_pkg::WORD_W-1:0] r_val;
    logic [bspc_pkg::WORD_W-1:0] r_rd_a;
    logic [bspc_pkg::WORD_W-1:0] r_rd_b;
    logic                        r_out_valid;
    logic [1:0]                  r_status;
    logic [bspc_pkg::WORD_W-1:0] r_data;
    logic                        r_pal;
    logic                        r_last;

    logic [CW-1:0] top_pos;
    logic [CW-1:0] pair_pos;
    logic [CW-1:0] down_pos;
    logic [CW-1:0] pos_a;
    logic          out_free;

    assign top_pos  = r_occ - CW'(1);
    assign pair_pos = top_pos - r_idx;
    assign down_pos = r_idx - CW'(1);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (i_cmd.rd_sel)
            bspc_pkg::RD_TOP:  pos_a = top_pos;
            bspc_pkg::RD_PAIR: pos_a = r_idx;
            bspc_pkg::RD_DOWN: pos_a = down_pos;
            default:           pos_a = top_pos;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op  <= i_operation;
            r_val <= i_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) begin
            r_mem[r_occ[IDXW-1:0]] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_a <= r_mem[pos_a[IDXW-1:0]];
            r_rd_b <= r_mem[pair_pos[IDXW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.occ_inc) begin
            r_occ <= r_occ + CW'(1);
        end else if (i_cmd.occ_dec) begin
            r_occ <= top_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.idx_op)
            bspc_pkg::IDX_HOLD: r_idx <= r_idx;
            bspc_pkg::IDX_CLR:  r_idx <= '0;
            bspc_pkg::IDX_TOP:  r_idx <= top_pos;
            bspc_pkg::IDX_INC:  r_idx <= r_idx + CW'(1);
            bspc_pkg::IDX_DEC:  r_idx <= down_pos;
            default:            r_idx <= r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.same_set) begin
            r_same <= 1'b1;
        end else if (i_cmd.same_upd && (r_rd_a != r_rd_b)) begin
            r_same <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status <= i_cmd.out_status;
            r_data   <= i_cmd.out_use_rd ? r_rd_a : '0;
            r_pal    <= i_cmd.out_pal | (i_cmd.out_pal_same & r_same);
            r_last   <= i_cmd.out_last;
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.full     = (r_occ == CW'(DEPTH));
    assign o_stat.empty    = (r_occ == '0);
    assign o_stat.idx_done = (r_idx == (r_occ >> 1));
    assign o_stat.idx_zero = (r_idx == '0);
    assign o_stat.out_free = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_data_word     = r_data;
    assign o_is_palindrome = r_pal;
    assign o_last          = r_last;

endmodule

`default_nettype wire

// ===== rtl/core/bounded_stack_with_palindrome_check.sv =====
// Bounded LIFO stack of signed 32-bit words with palindrome check and listing.
// i_in carries one transaction per operation: push, pop, palindrome or list,
// with the word to push. o_out returns result transactions: status, data word,
// palindrome flag and a last mark on the final result of each operation.
// Push, pop and palindrome give one result; list gives one per stored word,
// top first, or a single stack-empty result.
// One operation is in flight at a time. The controller decodes it in S_DISP,
// where a push or an empty-stack case loads its result; a pop reads the top
// word and loads it from S_POP; a palindrome check alternates S_PAL_RD and
// S_PAL_CMP, one pair at a time on the dual read port, and loads from S_PAL_OUT;
// a listing reads the top word, then S_LIST sends one word per cycle while the
// output register is free. i_in.ready returns in the same cycle that the final
// result appears in the output register, so a waiting result does not hold off the next operation.
// When o_out.ready stays low the controller holds in place and no result is
// dropped or repeated. Reset empties the stack and clears the output valid flag;
// no clearing pass runs.
`default_nettype none

`include "bounded_stack_with_palindrome_check_macros.svh"

module bounded_stack_with_palindrome_check #(
    parameter int DEPTH = bspc_pkg::DEPTH_DFLT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bspc_in_if.sink    i_in,
    bspc_out_if.source o_out
);

    bspc_pkg::t_cmd  s_cmd;
    bspc_pkg::t_stat s_stat;
    logic            in_ready;

    bspc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd),
        .o_in_ready (in_ready)
    );

    bspc_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (s_cmd),
        .i_operation     (i_in.operation),
        .i_push_value    (i_in.push_value),
        .i_out_ready     (o_out.ready),
        .o_stat          (s_stat),
        .o_out_valid     (o_out.valid),
        .o_status        (o_out.status),
        .o_data_word     (o_out.data_word),
        .o_is_palindrome (o_out.is_palindrome),
        .o_last          (o_out.last)
    );

    assign i_in.ready = in_ready;

    `BSPC_ASSERT_NEXT(a_one_in_flight, i_in.valid && i_in.ready, !i_in.ready, "input taken while busy")
    `BSPC_ASSERT(a_error_is_last, o_out.valid && (o_out.status == bspc_pkg::ST_OVERFLOW || o_out.status == bspc_pkg::ST_UNDERFLOW), o_out.last, "error result not marked last")
    `BSPC_ASSERT(a_list_busy, o_out.valid && !o_out.last, !i_in.ready, "ready during listing")
    `BSPC_ASSERT(a_full_not_empty, s_stat.full, !s_stat.empty, "stack both full and empty")

endmodule

`default_nettype wire
